FILE: rtl/core/gradient_non_maximum_suppression_top_macros.svh
// Assertion macros shared by the gradient suppression RTL.
// Needs no package; each use names its clock and active-low reset.
`ifndef GRADIENT_NON_MAXIMUM_SUPPRESSION_TOP_MACROS_SVH
`define GRADIENT_NON_MAXIMUM_SUPPRESSION_TOP_MACROS_SVH

// property must hold at every edge outside reset
`define GNMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen outside reset
`define GNMS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: rtl/core/gnms_pkg.sv
// Shared types and constants for the gradient non-maximum suppression block.
// No dependencies.
package gnms_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAG_BITS_DEF  = 11;

    localparam int CFG_BITS     = 13;
    localparam int CFG_IDX_BITS = 1;
    localparam int ROW_BITS     = CFG_BITS + 1;
    localparam int GRAD_BITS    = 11;
    localparam int SQ_BITS      = 2 * (GRAD_BITS + 1);
    localparam int BIN_BITS     = 2;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [BIN_BITS-1:0] BIN_HORIZ   = 2'd0;
    localparam logic [BIN_BITS-1:0] BIN_DIAG45  = 2'd1;
    localparam logic [BIN_BITS-1:0] BIN_VERT    = 2'd2;
    localparam logic [BIN_BITS-1:0] BIN_DIAG135 = 2'd3;

    // per-item control travelling from front to back; position flags refer
    // to the centre pixel whose result this item releases
    typedef struct packed {
        logic [BIN_BITS-1:0] bin;
        logic                has_out;
        logic                last;
        logic                top_ok;
        logic                bot_ok;
        logic                left_ok;
        logic                right_ok;
    } t_ctrl;

endpackage

FILE: rtl/core/gnms_if.sv
// Stream channel interfaces: pixel input and suppression result.
// Depends on gnms_pkg.
interface gnms_pix_if #(
    parameter int MAG_BITS = gnms_pkg::MAG_BITS_DEF
);
    import gnms_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [MAG_BITS-1:0]         magnitude;
    logic signed [GRAD_BITS-1:0] gradient_x;
    logic signed [GRAD_BITS-1:0] gradient_y;

    modport source (output valid, command, magnitude, gradient_x, gradient_y, input ready);
    modport sink   (input valid, command, magnitude, gradient_x, gradient_y, output ready);
endinterface

interface gnms_res_if #(
    parameter int MAG_BITS = gnms_pkg::MAG_BITS_DEF
);
    import gnms_pkg::*;

    logic                valid;
    logic                ready;
    logic [MAG_BITS-1:0] thinned_magnitude;
    logic [BIN_BITS-1:0] direction_bin;
    logic                frame_last;

    modport source (output valid, thinned_magnitude, direction_bin, frame_last, input ready);
    modport sink   (input valid, thinned_magnitude, direction_bin, frame_last, output ready);
endinterface

FILE: rtl/core/gnms_front.sv
// Front end: config registers, raster position tracking, drain handling and
// angle binning pipeline. Depends on gnms_pkg and gnms_pix_if.
module gnms_front #(
    parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH_DEF,
    parameter int MAG_BITS  = gnms_pkg::MAG_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gnms_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [gnms_pkg::CFG_BITS-1:0]     i_cfg_data,
    gnms_pix_if.sink                          i_pix,
    input  logic                              i_q_full,
    output logic                              o_push,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_push_col,
    output logic [MAG_BITS-1:0]               o_push_mag,
    output gnms_pkg::t_ctrl                   o_push_ctrl
);
    import gnms_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int WID_BITS = $clog2(MAX_WIDTH + 1);
    localparam logic [ROW_BITS-1:0] MAXW = ROW_BITS'(MAX_WIDTH);

    typedef struct packed {
        logic bx0;
        logic ay0;
        logic same;
    } t_grad;

    logic [CFG_BITS-1:0] r_frame_width, r_frame_height;
    logic [COL_BITS-1:0] r_col, n_col;
    logic [ROW_BITS-1:0] r_row, n_row;

    logic [ROW_BITS-1:0] fw_ext, w_full, h_ext;
    logic [WID_BITS-1:0] w_eff, col_ext;
    logic [CFG_BITS-1:0] h_eff;
    logic                col0, in_frame, drop, fen, acc, take;
    t_ctrl               n_ctrl;
    t_grad               n_grad;
    logic [GRAD_BITS-1:0] n_a, n_b;

    logic                 r_f1_v, r_f2_v, r_f3_v;
    logic [COL_BITS-1:0]  r_f1_col, r_f2_col, r_f3_col;
    logic [MAG_BITS-1:0]  r_f1_mag, r_f2_mag, r_f3_mag;
    t_ctrl                r_f1_ctrl, r_f2_ctrl, r_f3_ctrl;
    t_grad                r_f1_grad, r_f2_grad, r_f3_grad;
    logic [GRAD_BITS-1:0] r_f1_a, r_f1_b, r_f2_b, r_f2_dif;
    logic [GRAD_BITS:0]   r_f2_sum;
    logic                 r_f2_agtb, r_f3_agtb;
    logic [SQ_BITS-1:0]   r_f3_sq_sum, r_f3_sq_dif, r_f3_sq_b2;
    logic [SQ_BITS-1:0]   n_sq_sum, n_sq_dif, n_sq_b2;
    logic [BIN_BITS-1:0]  n_bin;

    // effective frame size
    assign fw_ext = ROW_BITS'(r_frame_width);
    assign w_full = (r_frame_width == '0) ? ROW_BITS'(1) : ((fw_ext > MAXW) ? MAXW : fw_ext);
    assign w_eff  = w_full[WID_BITS-1:0];
    assign h_eff  = (r_frame_height == '0) ? CFG_BITS'(1) : r_frame_height;
    assign h_ext  = ROW_BITS'(h_eff);

    assign col_ext  = WID_BITS'(r_col);
    assign col0     = (r_col == '0);
    assign in_frame = (r_row < h_ext);
    // a drain inside the frame is swallowed; a pixel past frame end drains
    assign drop     = (i_pix.command == CMD_DRAIN) && in_frame;

    assign fen         = !r_f3_v || !i_q_full;
    assign i_pix.ready = fen;
    assign acc         = i_pix.valid && fen;
    assign take        = acc && !drop;

    // centre pixel sits w+1 positions behind the incoming one
    always_comb begin
        n_ctrl         = '0;
        n_ctrl.bin     = BIN_HORIZ;
        n_ctrl.has_out = (r_row >= ROW_BITS'(2)) || ((r_row == ROW_BITS'(1)) && !col0);
        if (col0) begin
            n_ctrl.top_ok   = r_row > ROW_BITS'(2);
            n_ctrl.bot_ok   = (r_row - ROW_BITS'(1)) < h_ext;
            n_ctrl.left_ok  = w_eff > WID_BITS'(1);
            n_ctrl.right_ok = 1'b0;
            n_ctrl.last     = r_row == (h_ext + ROW_BITS'(1));
        end else begin
            n_ctrl.top_ok   = r_row > ROW_BITS'(1);
            n_ctrl.bot_ok   = r_row < h_ext;
            n_ctrl.left_ok  = r_col > COL_BITS'(1);
            n_ctrl.right_ok = 1'b1;
            n_ctrl.last     = 1'b0;
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (n_ctrl.last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_ext == (w_eff - WID_BITS'(1))) begin
            n_col = '0;
            n_row = r_row + ROW_BITS'(1);
        end else begin
            n_col = r_col + COL_BITS'(1);
        end
    end

    assign n_a = i_pix.gradient_y[GRAD_BITS-1] ? $unsigned(~i_pix.gradient_y + 1'b1)
                                                : $unsigned(i_pix.gradient_y);
    assign n_b = i_pix.gradient_x[GRAD_BITS-1] ? $unsigned(~i_pix.gradient_x + 1'b1)
                                                : $unsigned(i_pix.gradient_x);
    assign n_grad.bx0  = (i_pix.gradient_x == '0);
    assign n_grad.ay0  = (i_pix.gradient_y == '0);
    assign n_grad.same = (i_pix.gradient_x[GRAD_BITS-1] == i_pix.gradient_y[GRAD_BITS-1]);

    // config and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (take) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
        end else if (fen) begin
            r_f1_v <= take;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
        end
    end

    // tan(22.5) and tan(67.5) tests done exactly on integer squares
    assign n_sq_sum = SQ_BITS'(r_f2_sum) * SQ_BITS'(r_f2_sum);
    assign n_sq_dif = SQ_BITS'(r_f2_dif) * SQ_BITS'(r_f2_dif);
    assign n_sq_b2  = (SQ_BITS'(r_f2_b) * SQ_BITS'(r_f2_b)) << 1;

    always_ff @(posedge i_clk) begin
        if (fen) begin
            r_f1_col  <= r_col;
            r_f1_mag  <= i_pix.magnitude;
            r_f1_ctrl <= n_ctrl;
            r_f1_grad <= n_grad;
            r_f1_a    <= n_a;
            r_f1_b    <= n_b;

            r_f2_col  <= r_f1_col;
            r_f2_mag  <= r_f1_mag;
            r_f2_ctrl <= r_f1_ctrl;
            r_f2_grad <= r_f1_grad;
            r_f2_sum  <= {1'b0, r_f1_a} + {1'b0, r_f1_b};
            r_f2_dif  <= r_f1_a - r_f1_b;
            r_f2_agtb <= r_f1_a > r_f1_b;
            r_f2_b    <= r_f1_b;

            r_f3_col    <= r_f2_col;
            r_f3_mag    <= r_f2_mag;
            r_f3_ctrl   <= r_f2_ctrl;
            r_f3_grad   <= r_f2_grad;
            r_f3_agtb   <= r_f2_agtb;
            r_f3_sq_sum <= n_sq_sum;
            r_f3_sq_dif <= n_sq_dif;
            r_f3_sq_b2  <= n_sq_b2;
        end
    end

    always_comb begin
        if (r_f3_grad.bx0) begin
            n_bin = BIN_VERT;
        end else if (r_f3_grad.ay0) begin
            n_bin = BIN_HORIZ;
        end else if (r_f3_agtb && (r_f3_sq_dif > r_f3_sq_b2)) begin
            n_bin = BIN_VERT;
        end else if (r_f3_sq_sum > r_f3_sq_b2) begin
            n_bin = r_f3_grad.same ? BIN_DIAG45 : BIN_DIAG135;
        end else begin
            n_bin = BIN_HORIZ;
        end
    end

    always_comb begin
        o_push_ctrl     = r_f3_ctrl;
        o_push_ctrl.bin = n_bin;
    end

    assign o_push     = r_f3_v && !i_q_full;
    assign o_push_col = r_f3_col;
    assign o_push_mag = r_f3_mag;

endmodule

FILE: rtl/core/gnms_queue.sv
// Small register FIFO decoupling the front end from the window back end.
// Depends on gnms_pkg and the assertion macro header.
module gnms_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = gnms_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import gnms_pkg::*;
    `include "gradient_non_maximum_suppression_top_macros.svh"

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

    `GNMS_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full, "queue pushed while full")
    `GNMS_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && o_empty, "queue popped while empty")
    `GNMS_ASSERT(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == CNT_BITS'($past(r_count) + 1'b1)), "queue count lost a transaction")

endmodule

FILE: rtl/core/gnms_back.sv
// Back end: two line stores with bypass, 3x3 window, directional suppression
// and output register. Depends on gnms_pkg and gnms_res_if.
module gnms_back #(
    parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH_DEF,
    parameter int MAG_BITS  = gnms_pkg::MAG_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_q_col,
    input  logic [MAG_BITS-1:0]          i_q_mag,
    input  gnms_pkg::t_ctrl              i_q_ctrl,
    output logic                         o_q_pop,
    gnms_res_if.source                   o_res
);
    import gnms_pkg::*;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int LINE0_BITS = MAG_BITS + BIN_BITS;

    // line 0 holds the previous row with its bins, line 1 the row before
    logic [LINE0_BITS-1:0] r_line0 [MAX_WIDTH];
    logic [MAG_BITS-1:0]   r_line1 [MAX_WIDTH];
    logic [LINE0_BITS-1:0] r_rd0, r_fwd0, eff0, wdata0;
    logic [MAG_BITS-1:0]   r_rd1, r_fwd1, eff1, wdata1;
    logic                  r_fwd;

    logic                en, pop, wr;
    logic                r_v2, r_v3;
    logic [COL_BITS-1:0] r_col2;
    logic [MAG_BITS-1:0] r_mag2;
    t_ctrl               r_ctrl2, r_ctrl3;

    logic [MAG_BITS-1:0] r_win [3][3];
    logic [BIN_BITS-1:0] r_binc1, r_binc2;

    logic [MAG_BITS-1:0] centre, nb1, nb2, thinned;
    logic                ok1, ok2, keep;

    logic                r_out_valid;
    logic [MAG_BITS-1:0] r_out_mag;
    logic [BIN_BITS-1:0] r_out_bin;
    logic                r_out_last;

    assign en      = !r_out_valid || o_res.ready;
    assign pop     = en && !i_q_empty;
    assign wr      = en && r_v2;
    assign o_q_pop = pop;

    assign eff0   = r_fwd ? r_fwd0 : r_rd0;
    assign eff1   = r_fwd ? r_fwd1 : r_rd1;
    assign wdata0 = {r_ctrl2.bin, r_mag2};
    assign wdata1 = eff0[MAG_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_line0[r_col2] <= wdata0;
            r_line1[r_col2] <= wdata1;
        end
        if (pop) begin
            r_rd0 <= r_line0[i_q_col];
            r_rd1 <= r_line1[i_q_col];
        end
    end

    // one-pixel rows read the column being written in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (pop) begin
            r_fwd <= wr && (r_col2 == i_q_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_fwd0  <= wdata0;
            r_fwd1  <= wdata1;
            r_col2  <= i_q_col;
            r_mag2  <= i_q_mag;
            r_ctrl2 <= i_q_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v2        <= pop;
            r_v3        <= r_v2 && r_ctrl2.has_out;
            r_out_valid <= r_v3;
        end
    end

    // window shifts one column per transaction; column 2 is newest
    always_ff @(posedge i_clk) begin
        if (wr) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= eff1;
            r_win[1][2] <= eff0[MAG_BITS-1:0];
            r_win[2][2] <= r_mag2;
            r_binc2     <= eff0[LINE0_BITS-1:MAG_BITS];
            r_binc1     <= r_binc2;
            r_ctrl3     <= r_ctrl2;
        end
    end

    assign centre = r_win[1][1];

    always_comb begin
        nb1 = r_win[1][0];
        nb2 = r_win[1][2];
        ok1 = r_ctrl3.left_ok;
        ok2 = r_ctrl3.right_ok;
        case (r_binc1)
            BIN_HORIZ: begin
                nb1 = r_win[1][0];
                nb2 = r_win[1][2];
                ok1 = r_ctrl3.left_ok;
                ok2 = r_ctrl3.right_ok;
            end
            BIN_DIAG45: begin
                nb1 = r_win[0][0];
                nb2 = r_win[2][2];
                ok1 = r_ctrl3.top_ok && r_ctrl3.left_ok;
                ok2 = r_ctrl3.bot_ok && r_ctrl3.right_ok;
            end
            BIN_VERT: begin
                nb1 = r_win[0][1];
                nb2 = r_win[2][1];
                ok1 = r_ctrl3.top_ok;
                ok2 = r_ctrl3.bot_ok;
            end
            BIN_DIAG135: begin
                nb1 = r_win[0][2];
                nb2 = r_win[2][0];
                ok1 = r_ctrl3.top_ok && r_ctrl3.right_ok;
                ok2 = r_ctrl3.bot_ok && r_ctrl3.left_ok;
            end
            default: ;
        endcase
    end

    assign keep    = !((ok1 && (centre <= nb1)) || (ok2 && (centre <= nb2)));
    assign thinned = keep ? centre : '0;

    always_ff @(posedge i_clk) begin
        if (en && r_v3) begin
            r_out_mag  <= thinned;
            r_out_bin  <= r_binc1;
            r_out_last <= r_ctrl3.last;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.thinned_magnitude = r_out_mag;
    assign o_res.direction_bin     = r_out_bin;
    assign o_res.frame_last        = r_out_last;

endmodule

FILE: rtl/core/gradient_non_maximum_suppression_top.sv
// Top level of the Canny non-maximum suppression block over a 3x3 window.
// Depends on gnms_pkg, gnms_if, gnms_front, gnms_queue and gnms_back.
//
// Takes one transaction per clock, pixels in raster order, and sustains one
// result per clock while o_res.ready is high. The result for a pixel is
// released by the transaction arriving frame_width+1 positions later, so
// after the last pixel of a frame frame_width+1 drains flush the last row;
// frame_last marks the final result and the position counters then restart.
// From an accepting transaction to its result on the output register
// lie three front stages (position flags, sum and difference, squares),
// one queue slot, the line store read and the window stage. The rate is
// set by the two line stores, each read and written once per transaction
// at the current column, with a bypass for one-pixel rows. Line stores are
// not cleared; only entries written in the current frame are ever compared.
// Configuration writes restart the frame and must be issued while idle.
module gradient_non_maximum_suppression_top #(
    parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH_DEF,
    parameter int MAG_BITS  = gnms_pkg::MAG_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gnms_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [gnms_pkg::CFG_BITS-1:0]     i_cfg_data,
    gnms_pix_if.sink                          i_pix,
    gnms_res_if.source                        o_res
);
    import gnms_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int QW       = COL_BITS + MAG_BITS + $bits(t_ctrl);

    logic                push, pop, q_full, q_empty;
    logic [COL_BITS-1:0] push_col, q_col;
    logic [MAG_BITS-1:0] push_mag, q_mag;
    t_ctrl               push_ctrl, q_ctrl;
    logic [QW-1:0]       q_wdata, q_rdata;

    gnms_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAG_BITS  (MAG_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_col  (push_col),
        .o_push_mag  (push_mag),
        .o_push_ctrl (push_ctrl)
    );

    assign q_wdata = {push_col, push_mag, push_ctrl};

    gnms_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    assign {q_col, q_mag, q_ctrl} = q_rdata;

    gnms_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAG_BITS  (MAG_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_col   (q_col),
        .i_q_mag   (q_mag),
        .i_q_ctrl  (q_ctrl),
        .o_q_pop   (pop),
        .o_res     (o_res)
    );

endmodule
